/* hdl/b64_pkg.sv */
package b64_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } out_beat_t;

    // One character to be sent: either a sextet of the alphabet or a pad.
    typedef struct packed {
        logic       pad;
        logic [5:0] sextet;
    } slot_t;

    // Work for one accepted byte: slots 0 up to last_idx are sent in order.
    typedef struct packed {
        slot_t [3:0] slots;
        logic [1:0]  last_idx;
        logic        last;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [6:0] b64_char(input slot_t s);
        logic [6:0] v;
        logic [6:0] ch;
        v = {1'b0, s.sextet};
        if (s.pad) begin
            ch = PAD_CHAR;
        end
        else if (s.sextet < 6'd26) begin
            ch = v + 7'd65;
        end
        else if (s.sextet < 6'd52) begin
            ch = v + 7'd71;
        end
        else if (s.sextet < 6'd62) begin
            ch = v - 7'd4;
        end
        else if (s.sextet == 6'd62) begin
            ch = 7'd43;
        end
        else begin
            ch = 7'd47;
        end
        return ch;
    endfunction

endpackage

/* hdl/b64_front.sv */
module b64_front
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_beat_t  beat,
    output job_t      job
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;

    always_comb
    begin
        logic [7:0] b;
        b        = beat.data_byte;
        job      = '0;
        pos_next = pos_reg;
        left_next = left_reg;

        case (pos_reg)
            2'd1:
            begin
                job.slots[0].sextet = {left_reg[1:0], b[7:4]};
                job.last_idx        = 2'd0;
                pos_next            = 2'd2;
                left_next           = b[3:0];
            end
            2'd2:
            begin
                job.slots[0].sextet = {left_reg, b[7:6]};
                job.slots[1].sextet = b[5:0];
                job.last_idx        = 2'd1;
                pos_next            = 2'd0;
                left_next           = 4'd0;
            end
            default:
            begin
                job.slots[0].sextet = b[7:2];
                job.last_idx        = 2'd0;
                pos_next            = 2'd1;
                left_next           = {2'b00, b[1:0]};
            end
        endcase

        if (beat.final_byte) begin
            job.last = 1'b1;
            // Flush the kept bits as a character, then pad to a full group.
            case (pos_next)
                2'd1:
                begin
                    job.slots[1].sextet = {left_next[1:0], 4'd0};
                    job.slots[2].pad    = 1'b1;
                    job.slots[3].pad    = 1'b1;
                    job.last_idx        = 2'd3;
                end
                2'd2:
                begin
                    job.slots[1].sextet = {left_next, 2'd0};
                    job.slots[2].pad    = 1'b1;
                    job.last_idx        = 2'd2;
                end
                default:
                begin
                    job.last_idx = 2'd1;
                end
            endcase
            pos_next  = 2'd0;
            left_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= 2'd0;
            left_reg <= 4'd0;
        end
        else if (accept) begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

endmodule

/* hdl/b64_queue.sv */
module b64_queue
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head,
    output q_status_t status
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    job_t       q0_reg;
    job_t       q0_next;
    job_t       q1_reg;
    job_t       q1_next;

    always_comb
    begin
        count_next = count_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0) begin
                    q0_next = push_job;
                end
                else begin
                    q1_next = push_job;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next    = q1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1) begin
                    q0_next = push_job;
                end
                else begin
                    q0_next = q1_reg;
                    q1_next = push_job;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign head         = q0_reg;
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

/* hdl/b64_back.sv */
module b64_back
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  q_status_t status,
    output logic      pop,
    output logic      char_valid,
    input  logic      char_stall,
    output out_beat_t char_beat
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    out_beat_t  beat_reg;
    out_beat_t  beat_next;
    logic       load;
    logic       at_end;

    assign load   = !status.empty && (!valid_reg || !char_stall);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        beat_next  = beat_reg;
        valid_next = valid_reg && char_stall;
        if (load) begin
            valid_next         = 1'b1;
            beat_next.out_char = b64_char(head.slots[idx_reg]);
            beat_next.out_last = head.last && at_end;
            idx_next           = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign char_valid = valid_reg;
    assign char_beat  = beat_reg;

endmodule

/* hdl/base64_stream_encoder.sv */
// Streaming base64 encoder, standard alphabet with '=' padding.
// The byte channel (byte_valid, byte_stall, byte_beat) takes one message byte
// per beat with final_byte set on the last byte; every message has at least
// one byte. The char channel (char_valid, char_stall, char_beat) gives one
// ASCII character per beat, with out_last set on the final character.
// A byte yields one or two characters, and the last byte of a message up to
// four in all, so a three-byte group gives four characters at the char side.
// The first character of a byte passes through the queue register and then the
// output register; later ones follow one per clock while char_stall is low.
// Unstalled, the output port runs at one character per clock, the sustained rate.
// A two-entry queue of decoded bytes sits between the byte front end and the
// character sequencer, so bytes keep being taken while a character waits;
// byte_stall is high only while that queue is full.
// When the receiver stalls, the held character stays on char_beat and the
// queue fills up behind it. Reset empties the queue and the output register
// and starts a fresh message at the beginning of a group.
module base64_stream_encoder
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_beat_t  byte_beat,
    output logic      char_valid,
    input  logic      char_stall,
    output out_beat_t char_beat
);

    logic      push;
    logic      pop;
    job_t      front_job;
    job_t      head;
    q_status_t q_status;

    assign byte_stall = q_status.full;
    assign push       = byte_valid && !q_status.full;

    b64_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (push),
        .beat   (byte_beat),
        .job    (front_job)
    );

    b64_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    b64_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .status     (q_status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    a_short_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && !head.last) |-> (head.last_idx == 2'd0 || head.last_idx == 2'd1))
        else $error("a byte inside a message queued more than two characters");

    a_pad_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_status.empty && head.slots[head.last_idx].pad) |-> head.last)
        else $error("pad character queued outside the last byte of a message");

    a_push_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && q_status.empty) |=> !q_status.empty)
        else $error("pushed byte lost from the queue");
`endif

endmodule

/* test/base64_stream_encoder_tb.sv */
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
    import b64_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_beat_t  byte_beat = '0;
    logic      char_valid;
    logic      char_stall = 1'b0;
    out_beat_t char_beat;

    base64_stream_encoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat)
    );

    always #5 clk = ~clk;

    string     b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    out_beat_t expected_chars[$];
    logic [1:0] grp_pos = 2'd0;
    logic [3:0] kept_bits = 4'd0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        error_count = 0;

    function automatic logic [6:0] sextet_ascii(input logic [5:0] s);
        byte c;
        c = b64_alphabet[s];
        return c[6:0];
    endfunction

    task automatic push_char(input logic [6:0] c);
        out_beat_t e;
        e.out_char = c;
        e.out_last = 1'b0;
        expected_chars.push_back(e);
    endtask

    // Works out the characters that one accepted byte completes.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        if (grp_pos == 2'd1) begin
            push_char(sextet_ascii({kept_bits[1:0], b[7:4]}));
            kept_bits = b[3:0];
            grp_pos = 2'd2;
        end
        else if (grp_pos == 2'd2) begin
            push_char(sextet_ascii({kept_bits, b[7:6]}));
            push_char(sextet_ascii(b[5:0]));
            kept_bits = 4'd0;
            grp_pos = 2'd0;
        end
        else begin
            push_char(sextet_ascii(b[7:2]));
            kept_bits = {2'b00, b[1:0]};
            grp_pos = 2'd1;
        end
        if (fin) begin
            if (grp_pos == 2'd1) begin
                push_char(sextet_ascii({kept_bits[1:0], 4'b0000}));
                push_char(PAD_CHAR);
                push_char(PAD_CHAR);
            end
            else if (grp_pos == 2'd2) begin
                push_char(sextet_ascii({kept_bits, 2'b00}));
                push_char(PAD_CHAR);
            end
            expected_chars[expected_chars.size() - 1].out_last = 1'b1;
            grp_pos = 2'd0;
            kept_bits = 4'd0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat <= '{data_byte: b, final_byte: fin};
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        encode_byte(b, fin);
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    // One-byte messages get two characters and two pads.
    task automatic test_single_byte_messages();
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'h80});
    endtask

    // Two-byte messages get one pad, three-byte messages none.
    task automatic test_partial_groups();
        send_message('{8'hFF, 8'h00});
        send_message('{8'h00, 8'hFF});
        send_message('{8'hFF, 8'hFF, 8'hFF});
        send_message('{8'h00, 8'h00, 8'h00});
    endtask

    // Messages spanning groups, including the symbol character for sextet 62.
    task automatic test_multi_group();
        send_message('{8'hFB, 8'hEF, 8'hBE, 8'h01});
        send_message('{8'h14, 8'hFB, 8'h9C, 8'h03, 8'hD9});
    endtask

    task automatic test_random_messages(input int n_bytes);
        logic [7:0] msg[$];
        int         len;
        int         sent;
        sent = 0;
        while (sent < n_bytes) begin
            msg.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
            repeat (len) begin
                case ($urandom_range(7))
                    0: msg.push_back(8'h00);
                    1: msg.push_back(8'hFF);
                    default: msg.push_back(8'($urandom_range(255)));
                endcase
            end
            send_message(msg);
            sent += len;
        end
    endtask

    // Receiver side: random stall and the comparison of each accepted beat.
    always @(posedge clk) begin : char_check
        out_beat_t want;
        if (rst_n && char_valid && !char_stall) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected char beat: out_char %0d out_last %0d",
                       char_beat.out_char, char_beat.out_last);
                error_count++;
            end
            else begin
                want = expected_chars.pop_front();
                if (char_beat.out_char !== want.out_char) begin
                    $error("out_char: expected %0d, actual %0d",
                           want.out_char, char_beat.out_char);
                    error_count++;
                end
                if (char_beat.out_last !== want.out_last) begin
                    $error("out_last: expected %0d, actual %0d",
                           want.out_last, char_beat.out_last);
                    error_count++;
                end
            end
        end
        char_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_stall_pct = 80;
        test_single_byte_messages();
        test_partial_groups();
        test_multi_group();
        test_random_messages(65);

        send_idle_pct = 80;
        recv_stall_pct = 18;
        test_random_messages(65);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_messages(70);

        byte_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end
        else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/b64_pkg.sv
hdl/b64_front.sv
hdl/b64_queue.sv
hdl/b64_back.sv
hdl/base64_stream_encoder.sv
test/base64_stream_encoder_tb.sv
